// File: design/fpp_pkg.sv
// Shared types and constants for the chess position string parser.
// No dependencies; every other design file imports this package.
package fpp_pkg;

  localparam int BOARD_SQUARES = 64;
  localparam int COUNT_WIDTH   = 16;

  // Field numbers within the position string
  localparam logic [2:0] FIELD_PLACEMENT = 3'd0;
  localparam logic [2:0] FIELD_SIDE      = 3'd1;
  localparam logic [2:0] FIELD_CASTLING  = 3'd2;
  localparam logic [2:0] FIELD_PASSANT   = 3'd3;
  localparam logic [2:0] FIELD_HALFMOVE  = 3'd4;
  localparam logic [2:0] FIELD_FULLMOVE  = 3'd5;
  localparam logic [2:0] FIELD_LAST      = 3'd7;

  // Characters
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_1       = 8'h31;
  localparam logic [7:0] CH_3       = 8'h33;
  localparam logic [7:0] CH_6       = 8'h36;
  localparam logic [7:0] CH_8       = 8'h38;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_K = 8'h4B;
  localparam logic [7:0] CH_UPPER_Q = 8'h51;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_H = 8'h68;
  localparam logic [7:0] CH_LOWER_K = 8'h6B;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_LOWER_Q = 8'h71;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_W = 8'h77;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Colour and piece codes
  localparam logic [1:0] COLOR_NONE  = 2'd0;
  localparam logic [1:0] COLOR_WHITE = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  localparam logic [2:0] KIND_EMPTY  = 3'd0;
  localparam logic [2:0] KIND_PAWN   = 3'd1;
  localparam logic [2:0] KIND_ROOK   = 3'd2;
  localparam logic [2:0] KIND_KNIGHT = 3'd3;
  localparam logic [2:0] KIND_BISHOP = 3'd4;
  localparam logic [2:0] KIND_QUEEN  = 3'd5;
  localparam logic [2:0] KIND_KING   = 3'd6;

  localparam logic signed [7:0] PASSANT_NONE = -8'sd1;
  localparam logic signed [8:0] PASSANT_MAX  = 9'sd127;
  localparam logic signed [8:0] RANK3_OFFSET = 9'sd16;
  localparam logic signed [8:0] RANK6_OFFSET = 9'sd40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARES,
    ST_HEADER
  } fpp_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_square;
    logic emit_header;
  } fpp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic run_start;    // request being accepted produces square results
    logic end_request;  // request being offered closes the string
    logic out_free;     // output register can take a result this cycle
    logic last_square;  // one square result left in the current run
    logic hdr_pending;  // header result follows the current run
  } fpp_status_t;

endpackage

// File: design/fpp_datapath.sv
// Datapath of the position parser: parse state, square run and output register.
// Depends on fpp_pkg; driven by fpp_ctrl through command and status structs.
module fpp_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  fpp_pkg::fpp_cmd_t      cmd,
  output fpp_pkg::fpp_status_t   status,
  input  logic [7:0]             character,
  input  logic                   end_of_string,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   square_valid,
  output logic [5:0]             square_index,
  output logic [1:0]             piece_color,
  output logic [2:0]             piece_kind,
  output logic                   header_valid,
  output logic [1:0]             side_to_move,
  output logic [3:0]             castling_rights,
  output logic signed [7:0]      en_passant_square,
  output logic [15:0]            halfmove_count,
  output logic [15:0]            fullmove_count,
  output logic                   last_result
);
  import fpp_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_CAP = {COUNT_WIDTH{1'b1}};
  localparam logic [6:0]             SQUARE_END = 7'(BOARD_SQUARES);

  // Parse state
  logic [2:0]             field_number, field_number_next;
  logic [6:0]             next_square, next_square_next;
  logic [2:0]             position_in_field, position_in_field_next;
  logic [1:0]             side_value, side_value_next;
  logic [3:0]             castling_bits, castling_bits_next;
  logic signed [7:0]      passant_value, passant_value_next;
  logic [COUNT_WIDTH-1:0] halfmove_value, halfmove_value_next;
  logic [COUNT_WIDTH-1:0] fullmove_value, fullmove_value_next;
  logic                   digits_stopped, digits_stopped_next;

  // Pending square run
  logic [3:0]             run_count, run_count_next;
  logic [1:0]             run_color, run_color_next;
  logic [2:0]             run_kind, run_kind_next;
  logic                   hdr_pending, hdr_pending_next;

  logic                   piece_hit;
  logic [1:0]             piece_col;
  logic [2:0]             piece_knd;
  logic [6:0]             squares_left;
  logic [3:0]             item_run;
  logic [2:0]             field_after_space;
  logic signed [8:0]      passant_sum;
  logic                   is_digit;

  function automatic logic [COUNT_WIDTH-1:0] count_step(
    input logic [COUNT_WIDTH-1:0] value,
    input logic [3:0]             digit
  );
    logic [COUNT_WIDTH+3:0] wide;
    wide = (COUNT_WIDTH+4)'(value);
    wide = (wide << 3) + (wide << 1) + (COUNT_WIDTH+4)'(digit);
    if (wide > (COUNT_WIDTH+4)'(COUNT_CAP)) begin
      return COUNT_CAP;
    end
    return wide[COUNT_WIDTH-1:0];
  endfunction

  // Piece letter decode
  always_comb begin
    logic [7:0] lower;
    lower     = character;
    piece_hit = 1'b0;
    piece_col = COLOR_WHITE;
    piece_knd = KIND_EMPTY;
    if (character inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
      piece_col = COLOR_BLACK;
      piece_hit = 1'b1;
    end else if (character inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
      lower     = character + 8'd32;
      piece_hit = 1'b1;
    end
    case (lower)
      CH_LOWER_P: piece_knd = KIND_PAWN;
      CH_LOWER_R: piece_knd = KIND_ROOK;
      CH_LOWER_N: piece_knd = KIND_KNIGHT;
      CH_LOWER_B: piece_knd = KIND_BISHOP;
      CH_LOWER_Q: piece_knd = KIND_QUEEN;
      CH_LOWER_K: piece_knd = KIND_KING;
      default:    piece_hit = 1'b0;
    endcase
  end

  // Length of the run this request would produce
  always_comb begin
    squares_left = SQUARE_END - next_square;
    item_run     = 4'd0;
    if (field_number == FIELD_PLACEMENT) begin
      if (piece_hit) begin
        item_run = (squares_left != 7'd0) ? 4'd1 : 4'd0;
      end else if (character inside {[CH_1:CH_8]}) begin
        item_run = (7'(character[3:0]) < squares_left) ? character[3:0]
                                                       : squares_left[3:0];
      end
    end
  end

  assign field_after_space = (field_number < FIELD_LAST) ? field_number + 3'd1
                                                         : field_number;
  assign is_digit    = character inside {[CH_0:CH_9]};
  assign passant_sum = 9'(passant_value) +
                       ((character == CH_3) ? RANK3_OFFSET : RANK6_OFFSET);

  always_comb begin
    field_number_next      = field_number;
    next_square_next       = next_square;
    position_in_field_next = position_in_field;
    side_value_next        = side_value;
    castling_bits_next     = castling_bits;
    passant_value_next     = passant_value;
    halfmove_value_next    = halfmove_value;
    fullmove_value_next    = fullmove_value;
    digits_stopped_next    = digits_stopped;
    run_count_next         = run_count;
    run_color_next         = run_color;
    run_kind_next          = run_kind;
    hdr_pending_next       = hdr_pending;

    if (cmd.accept) begin
      hdr_pending_next = end_of_string;
      run_count_next   = 4'd0;
      if (character == CH_SPACE) begin
        field_number_next      = field_after_space;
        position_in_field_next = 3'd0;
        digits_stopped_next    = 1'b0;
        case (field_after_space)
          FIELD_SIDE:     side_value_next     = COLOR_NONE;
          FIELD_CASTLING: castling_bits_next  = 4'd0;
          FIELD_HALFMOVE: halfmove_value_next = '0;
          FIELD_FULLMOVE: fullmove_value_next = '0;
          default: ;
        endcase
      end else begin
        case (field_number)
          FIELD_PLACEMENT: begin
            run_count_next = item_run;
            run_color_next = piece_hit ? piece_col : COLOR_NONE;
            run_kind_next  = piece_hit ? piece_knd : KIND_EMPTY;
          end
          FIELD_SIDE: begin
            if (position_in_field == 3'd0) begin
              side_value_next = (character == CH_LOWER_W) ? COLOR_WHITE :
                                (character == CH_LOWER_B) ? COLOR_BLACK : COLOR_NONE;
            end
          end
          FIELD_CASTLING: begin
            if ((position_in_field == 3'd0 && character == CH_UPPER_K) ||
                (position_in_field == 3'd1 && character == CH_UPPER_Q) ||
                (position_in_field == 3'd2 && character == CH_LOWER_K) ||
                (position_in_field == 3'd3 && character == CH_LOWER_Q)) begin
              castling_bits_next = castling_bits | (4'd1 << position_in_field[1:0]);
            end
          end
          FIELD_PASSANT: begin
            if (character == CH_DASH) begin
              passant_value_next = PASSANT_NONE;
            end else if (character inside {[CH_LOWER_A:CH_LOWER_H]}) begin
              passant_value_next = 8'(character - CH_LOWER_A);
            end else if (character == CH_3 || character == CH_6) begin
              passant_value_next = (passant_sum > PASSANT_MAX) ? 8'(PASSANT_MAX)
                                                               : passant_sum[7:0];
            end else begin
              side_value_next = COLOR_NONE;
            end
          end
          FIELD_HALFMOVE: begin
            if (!digits_stopped) begin
              if (is_digit) halfmove_value_next = count_step(halfmove_value,
                                                             character[3:0]);
              else          digits_stopped_next = 1'b1;
            end
          end
          FIELD_FULLMOVE: begin
            if (!digits_stopped) begin
              if (is_digit) fullmove_value_next = count_step(fullmove_value,
                                                             character[3:0]);
              else          digits_stopped_next = 1'b1;
            end
          end
          default: ;
        endcase
        if (position_in_field < 3'd7) begin
          position_in_field_next = position_in_field + 3'd1;
        end
      end
    end

    if (cmd.emit_square) begin
      next_square_next = next_square + 7'd1;
      run_count_next   = run_count - 4'd1;
    end

    // Header closes the string: return to the reset state
    if (cmd.emit_header) begin
      field_number_next      = FIELD_PLACEMENT;
      next_square_next       = 7'd0;
      position_in_field_next = 3'd0;
      side_value_next        = COLOR_NONE;
      castling_bits_next     = 4'd0;
      passant_value_next     = PASSANT_NONE;
      halfmove_value_next    = '0;
      fullmove_value_next    = '0;
      digits_stopped_next    = 1'b0;
      hdr_pending_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number      <= FIELD_PLACEMENT;
      next_square       <= 7'd0;
      position_in_field <= 3'd0;
      side_value        <= COLOR_NONE;
      castling_bits     <= 4'd0;
      passant_value     <= PASSANT_NONE;
      halfmove_value    <= '0;
      fullmove_value    <= '0;
      digits_stopped    <= 1'b0;
      run_count         <= 4'd0;
      hdr_pending       <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      field_number      <= field_number_next;
      next_square       <= next_square_next;
      position_in_field <= position_in_field_next;
      side_value        <= side_value_next;
      castling_bits     <= castling_bits_next;
      passant_value     <= passant_value_next;
      halfmove_value    <= halfmove_value_next;
      fullmove_value    <= fullmove_value_next;
      digits_stopped    <= digits_stopped_next;
      run_count         <= run_count_next;
      hdr_pending       <= hdr_pending_next;
      if (cmd.emit_square || cmd.emit_header) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_color <= run_color_next;
    run_kind  <= run_kind_next;
    if (cmd.emit_square) begin
      square_valid      <= 1'b1;
      square_index      <= next_square[5:0];
      piece_color       <= run_color;
      piece_kind        <= run_kind;
      header_valid      <= 1'b0;
      side_to_move      <= COLOR_NONE;
      castling_rights   <= 4'd0;
      en_passant_square <= 8'sd0;
      halfmove_count    <= 16'd0;
      fullmove_count    <= 16'd0;
      last_result       <= (run_count == 4'd1) && !hdr_pending;
    end else if (cmd.emit_header) begin
      square_valid      <= 1'b0;
      square_index      <= 6'd0;
      piece_color       <= COLOR_NONE;
      piece_kind        <= KIND_EMPTY;
      header_valid      <= 1'b1;
      side_to_move      <= side_value;
      castling_rights   <= castling_bits;
      en_passant_square <= passant_value;
      halfmove_count    <= 16'(halfmove_value);
      fullmove_count    <= 16'(fullmove_value);
      last_result       <= 1'b1;
    end
  end

  assign status.run_start   = (item_run != 4'd0) && (character != CH_SPACE);
  assign status.end_request = end_of_string;
  assign status.out_free    = !out_valid || out_ready;
  assign status.last_square = (run_count == 4'd1);
  assign status.hdr_pending = hdr_pending;

endmodule

// File: design/fpp_ctrl.sv
// Sequencer of the position parser: takes requests and issues one result per cycle while the output register is free.
// Depends on fpp_pkg; commands fpp_datapath.
module fpp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fpp_pkg::fpp_status_t  status,
  output fpp_pkg::fpp_cmd_t     cmd
);
  import fpp_pkg::*;

  fpp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.accept      = 1'b0;
    cmd.emit_square = 1'b0;
    cmd.emit_header = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.run_start) begin
            state_next = ST_SQUARES;
          end else if (status.end_request) begin
            state_next = ST_HEADER;
          end
        end
      end
      ST_SQUARES: begin
        if (status.out_free) begin
          cmd.emit_square = 1'b1;
          if (status.last_square) begin
            state_next = status.hdr_pending ? ST_HEADER : ST_IDLE;
          end
        end
      end
      ST_HEADER: begin
        if (status.out_free) begin
          cmd.emit_header = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/fen_position_parser.sv
// Channel  | handshake           | payload
// ---------+---------------------+------------------------------------------------------
// input    | in_valid / in_ready | character, end_of_string
// output   | out_valid/out_ready | square_valid, square_index, piece_color, piece_kind,
//          |                     | header_valid, side_to_move, castling_rights,
//          |                     | en_passant_square, halfmove_count, fullmove_count,
//          |                     | last_result
//
// A request is taken in ST_IDLE; its square results then follow from ST_SQUARES, since
// the sequencer in fpp_ctrl issues one result per cycle, while out_ready allows, into a single output
// register. The header result on end of string is issued from ST_HEADER after them.
// Reset (rst, synchronous) clears the sequencer, the parse state and out_valid.
// out_ready low holds the output register and stalls the sequencer; a request is
// taken only once the previous one has issued all its results.
// Top level; depends on fpp_pkg, fpp_ctrl and fpp_datapath.
module fen_position_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        character,
  input  logic              end_of_string,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              square_valid,
  output logic [5:0]        square_index,
  output logic [1:0]        piece_color,
  output logic [2:0]        piece_kind,
  output logic              header_valid,
  output logic [1:0]        side_to_move,
  output logic [3:0]        castling_rights,
  output logic signed [7:0] en_passant_square,
  output logic [15:0]       halfmove_count,
  output logic [15:0]       fullmove_count,
  output logic              last_result
);
  import fpp_pkg::*;

  fpp_cmd_t    cmd;
  fpp_status_t status;

  fpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fpp_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .character         (character),
    .end_of_string     (end_of_string),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .square_valid      (square_valid),
    .square_index      (square_index),
    .piece_color       (piece_color),
    .piece_kind        (piece_kind),
    .header_valid      (header_valid),
    .side_to_move      (side_to_move),
    .castling_rights   (castling_rights),
    .en_passant_square (en_passant_square),
    .halfmove_count    (halfmove_count),
    .fullmove_count    (fullmove_count),
    .last_result       (last_result)
  );

`ifndef SYNTHESIS
  // Every result is either a square or the header, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (square_valid != header_valid))
    else $error("result is neither a single square nor a header");

  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && header_valid) |-> last_result)
    else $error("header result not marked last");

  // End of string always produces a header, so the sequencer must be busy
  a_eos_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && end_of_string) |=> !in_ready)
    else $error("request taken before header issued");

  // A held result that is not the last one means more results are still to be loaded
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_result) |-> !in_ready)
    else $error("request taken with square results still owed");
`endif

endmodule

// File: tb/sv/fpp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for fen_position_parser: watches both channels, predicts every square
// and header result from the accepted characters and compares them in arrival order.
// Depends on fpp_pkg for the character, field, colour and piece codes.
module fpp_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        character,
  input  logic              end_of_string,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              square_valid,
  input  logic [5:0]        square_index,
  input  logic [1:0]        piece_color,
  input  logic [2:0]        piece_kind,
  input  logic              header_valid,
  input  logic [1:0]        side_to_move,
  input  logic [3:0]        castling_rights,
  input  logic signed [7:0] en_passant_square,
  input  logic [15:0]       halfmove_count,
  input  logic [15:0]       fullmove_count,
  input  logic              last_result,
  output int                mismatch_count,
  output int                results_awaited
);
  import fpp_pkg::*;

  typedef struct packed {
    logic        sq_valid;
    logic [5:0]  sq_index;
    logic [1:0]  color;
    logic [2:0]  kind;
    logic        hdr_valid;
    logic [1:0]  side;
    logic [3:0]  castle;
    logic [7:0]  passant;
    logic [15:0] halfmoves;
    logic [15:0] fullmoves;
    logic        last;
  } parse_result_t;

  localparam int     PRINT_LIMIT = 40;
  localparam longint COUNT_CAP   = (longint'(1) << COUNT_WIDTH) - 1;

  // Parse state of the string being received
  logic [2:0]    field_num;
  logic [6:0]    next_sq;
  logic [2:0]    field_pos;
  logic [1:0]    side;
  logic [3:0]    castle;
  int            passant;
  longint        halfmoves;
  longint        fullmoves;
  bit            digits_stopped;

  parse_result_t predicted_results[$];
  parse_result_t observed;
  parse_result_t wanted;
  int            results_seen;

  initial begin
    mismatch_count  = 0;
    results_awaited = 0;
    results_seen    = 0;
  end

  task automatic clear_parse_state();
    field_num      = FIELD_PLACEMENT;
    next_sq        = '0;
    field_pos      = '0;
    side           = COLOR_NONE;
    castle         = '0;
    passant        = -1;
    halfmoves      = 0;
    fullmoves      = 0;
    digits_stopped = 1'b0;
  endtask

  // Decimal accumulation; the first non-digit freezes the field
  function automatic longint accumulate_count(longint value, logic [7:0] ch);
    if (digits_stopped) return value;
    if (ch < CH_0 || ch > CH_9) begin
      digits_stopped = 1'b1;
      return value;
    end
    value = value * 10 + longint'(ch - CH_0);
    return (value > COUNT_CAP) ? COUNT_CAP : value;
  endfunction

  task automatic parse_character(input logic [7:0] ch, input logic eos);
    parse_result_t batch[$];
    parse_result_t r;
    logic [7:0]    lower;
    logic [1:0]    color;
    logic [2:0]    kind;
    int            run;
    color = COLOR_NONE;
    kind  = KIND_EMPTY;
    lower = ch;
    if (ch == CH_SPACE) begin
      if (field_num != FIELD_LAST) field_num = field_num + 3'd1;
      field_pos      = '0;
      digits_stopped = 1'b0;
      case (field_num)
        FIELD_SIDE:     side = COLOR_NONE;
        FIELD_CASTLING: castle = '0;
        FIELD_HALFMOVE: halfmoves = 0;
        FIELD_FULLMOVE: fullmoves = 0;
        default: ;
      endcase
    end else begin
      case (field_num)
        FIELD_PLACEMENT: begin
          if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            color = COLOR_WHITE;
            lower = ch + (CH_LOWER_A - CH_UPPER_A);
          end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            color = COLOR_BLACK;
          end
          if (color != COLOR_NONE) begin
            case (lower)
              CH_LOWER_P: kind = KIND_PAWN;
              CH_LOWER_R: kind = KIND_ROOK;
              CH_LOWER_N: kind = KIND_KNIGHT;
              CH_LOWER_B: kind = KIND_BISHOP;
              CH_LOWER_Q: kind = KIND_QUEEN;
              CH_LOWER_K: kind = KIND_KING;
              default:    kind = KIND_EMPTY;
            endcase
          end
          if (kind != KIND_EMPTY) begin
            if (next_sq < BOARD_SQUARES) begin
              r          = '0;
              r.sq_valid = 1'b1;
              r.sq_index = next_sq[5:0];
              r.color    = color;
              r.kind     = kind;
              batch.push_back(r);
              next_sq++;
            end
          end else if (ch >= CH_1 && ch <= CH_8) begin
            // an empty-square run stops at the board edge
            run = int'(ch - CH_0);
            while (run > 0 && next_sq < BOARD_SQUARES) begin
              r          = '0;
              r.sq_valid = 1'b1;
              r.sq_index = next_sq[5:0];
              batch.push_back(r);
              next_sq++;
              run--;
            end
          end
        end
        FIELD_SIDE: begin
          if (field_pos == 3'd0)
            side = (ch == CH_LOWER_W) ? COLOR_WHITE :
                   (ch == CH_LOWER_B) ? COLOR_BLACK : COLOR_NONE;
        end
        FIELD_CASTLING: begin
          if ((field_pos == 3'd0 && ch == CH_UPPER_K) ||
              (field_pos == 3'd1 && ch == CH_UPPER_Q) ||
              (field_pos == 3'd2 && ch == CH_LOWER_K) ||
              (field_pos == 3'd3 && ch == CH_LOWER_Q))
            castle[field_pos[1:0]] = 1'b1;
        end
        FIELD_PASSANT: begin
          if (ch == CH_DASH) begin
            passant = -1;
          end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_H) begin
            passant = int'(ch - CH_LOWER_A);
          end else if (ch == CH_3 || ch == CH_6) begin
            passant += (ch == CH_3) ? int'(RANK3_OFFSET) : int'(RANK6_OFFSET);
            if (passant > int'(PASSANT_MAX)) passant = int'(PASSANT_MAX);
          end else begin
            side = COLOR_NONE;
          end
        end
        FIELD_HALFMOVE: halfmoves = accumulate_count(halfmoves, ch);
        FIELD_FULLMOVE: fullmoves = accumulate_count(fullmoves, ch);
        default: ;
      endcase
      if (field_pos != 3'd7) field_pos = field_pos + 3'd1;
    end
    if (eos) begin
      r           = '0;
      r.hdr_valid = 1'b1;
      r.side      = side;
      r.castle    = castle;
      r.passant   = passant[7:0];
      r.halfmoves = halfmoves[15:0];
      r.fullmoves = fullmoves[15:0];
      batch.push_back(r);
      clear_parse_state();
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) predicted_results.push_back(batch[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] result %0d: %s is %0h, predicted %0h",
               $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse_state();
      predicted_results.delete();
    end else begin
      // compare first: a result never belongs to the request taken at this edge
      if (out_valid && out_ready) begin
        observed = '{square_valid, square_index, piece_color, piece_kind, header_valid,
                     side_to_move, castling_rights, en_passant_square, halfmove_count,
                     fullmove_count, last_result};
        if (predicted_results.size() == 0) begin
          report_mismatch("unpredicted result count", 16'd1, 16'd0);
        end else begin
          wanted = predicted_results.pop_front();
          if (observed.sq_valid !== wanted.sq_valid)
            report_mismatch("square_valid", 16'(observed.sq_valid),
                            16'(wanted.sq_valid));
          if (observed.sq_index !== wanted.sq_index)
            report_mismatch("square_index", 16'(observed.sq_index),
                            16'(wanted.sq_index));
          if (observed.color !== wanted.color)
            report_mismatch("piece_color", 16'(observed.color), 16'(wanted.color));
          if (observed.kind !== wanted.kind)
            report_mismatch("piece_kind", 16'(observed.kind), 16'(wanted.kind));
          if (observed.hdr_valid !== wanted.hdr_valid)
            report_mismatch("header_valid", 16'(observed.hdr_valid),
                            16'(wanted.hdr_valid));
          if (observed.side !== wanted.side)
            report_mismatch("side_to_move", 16'(observed.side), 16'(wanted.side));
          if (observed.castle !== wanted.castle)
            report_mismatch("castling_rights", 16'(observed.castle),
                            16'(wanted.castle));
          if (observed.passant !== wanted.passant)
            report_mismatch("en_passant_square", 16'(observed.passant),
                            16'(wanted.passant));
          if (observed.halfmoves !== wanted.halfmoves)
            report_mismatch("halfmove_count", observed.halfmoves, wanted.halfmoves);
          if (observed.fullmoves !== wanted.fullmoves)
            report_mismatch("fullmove_count", observed.fullmoves, wanted.fullmoves);
          if (observed.last !== wanted.last)
            report_mismatch("last_result", 16'(observed.last), 16'(wanted.last));
        end
        results_seen++;
      end
      if (in_valid && in_ready) parse_character(character, end_of_string);
    end
    results_awaited = predicted_results.size();
  end

endmodule

// File: tb/sv/tb_fen_position_parser.sv
`timescale 1ns / 1ps
// Top of the fen_position_parser testbench: clock, reset, position-string stimulus,
// output backpressure and the verdict. Depends on fpp_pkg and fpp_result_checker.
module tb_fen_position_parser;
  import fpp_pkg::*;

  localparam int         ITEM_TARGET  = 420;
  localparam int         CALM_ITEMS   = 60;
  localparam int         HOLD_AFTER   = 150;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CASE_SHIFT   = CH_LOWER_A - CH_UPPER_A;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic [7:0]        character     = '0;
  logic              end_of_string = 1'b0;
  logic              out_ready     = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic              square_valid;
  logic [5:0]        square_index;
  logic [1:0]        piece_color;
  logic [2:0]        piece_kind;
  logic              header_valid;
  logic [1:0]        side_to_move;
  logic [3:0]        castling_rights;
  logic signed [7:0] en_passant_square;
  logic [15:0]       halfmove_count;
  logic [15:0]       fullmove_count;
  logic              last_result;
  int                mismatch_count;
  int                results_awaited;

  logic [7:0] position_text[$];
  int         items_sent       = 0;
  bit         calm             = 1'b0;
  bit         long_hold_done   = 1'b0;
  int         sender_idle_odds = 0;
  int         cycle_count      = 0;

  fen_position_parser dut (.*);

  fpp_result_checker result_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[fen_position_parser] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] random_digit(input int lo, input int hi);
    return 8'(CH_0 + $urandom_range(lo, hi));
  endfunction

  function automatic logic [7:0] random_piece();
    logic [7:0] p;
    case ($urandom_range(0, 5))
      0:       p = CH_LOWER_P;
      1:       p = CH_LOWER_R;
      2:       p = CH_LOWER_N;
      3:       p = CH_LOWER_B;
      4:       p = CH_LOWER_Q;
      default: p = CH_LOWER_K;
    endcase
    return $urandom_range(0, 1) ? p - CASE_SHIFT : p;
  endfunction

  // Move counter text: mostly short numbers, sometimes long enough to saturate
  task automatic append_count();
    int n;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
    repeat (n) position_text.push_back(random_digit(0, 9));
    if ($urandom_range(0, 5) == 0) begin
      position_text.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
      position_text.push_back(random_digit(0, 9));
    end
  endtask

  task automatic compose_position(input int style);
    int         filled;
    int         d;
    int         n;
    logic [7:0] castle_chars[4];
    castle_chars = '{CH_UPPER_K, CH_UPPER_Q, CH_LOWER_K, CH_LOWER_Q};
    position_text.delete();
    if (style >= 8) begin
      // raw noise with stray field breaks
      n = $urandom_range(1, 24);
      repeat (n)
        position_text.push_back($urandom_range(0, 4) == 0 ? CH_SPACE :
                                8'($urandom_range(0, 255)));
      return;
    end
    for (int rank = 0; rank < 8; rank++) begin
      filled = 0;
      while (filled < 8) begin
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 2))
            0:       position_text.push_back(CH_0);
            1:       position_text.push_back(CH_9);
            default: position_text.push_back(8'($urandom_range(128, 255)));
          endcase
        end
        if ($urandom_range(0, 2) == 0) begin
          d = $urandom_range(1, 8 - filled);
          position_text.push_back(8'(CH_0 + d));
          filled += d;
        end else begin
          position_text.push_back(random_piece());
          filled++;
        end
      end
      if (rank < 7) position_text.push_back(CH_SLASH);
    end
    // overrun past the last square
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        position_text.push_back($urandom_range(0, 1) ? random_piece() : random_digit(1, 8));
    position_text.push_back(CH_SPACE);
    if ($urandom_range(0, 9) == 0) position_text.push_back(CH_SPACE);
    case ($urandom_range(0, 5))
      0, 1:    position_text.push_back(CH_LOWER_W);
      2, 3:    position_text.push_back(CH_LOWER_B);
      default: position_text.push_back(8'($urandom_range(33, 255)));
    endcase
    if ($urandom_range(0, 5) == 0)
      position_text.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
    position_text.push_back(CH_SPACE);
    if ($urandom_range(0, 3) == 0) begin
      position_text.push_back(CH_DASH);
    end else if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 5))
        position_text.push_back(castle_chars[$urandom_range(0, 3)]);
    end else begin
      n = 0;
      foreach (castle_chars[i])
        if ($urandom_range(0, 1)) begin
          position_text.push_back(castle_chars[i]);
          n++;
        end
      if (n == 0) position_text.push_back(CH_DASH);
    end
    position_text.push_back(CH_SPACE);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: position_text.push_back(CH_DASH);
      4, 5, 6: begin
        position_text.push_back(8'(CH_LOWER_A + $urandom_range(0, 7)));
        position_text.push_back($urandom_range(0, 1) ? CH_3 : CH_6);
      end
      default: begin
        repeat ($urandom_range(1, 4))
          case ($urandom_range(0, 3))
            0:       position_text.push_back(CH_3);
            1:       position_text.push_back(CH_6);
            2:       position_text.push_back(8'(CH_LOWER_A + $urandom_range(0, 7)));
            default: position_text.push_back(8'($urandom_range(33, 255)));
          endcase
      end
    endcase
    position_text.push_back(CH_SPACE);
    append_count();
    position_text.push_back(CH_SPACE);
    append_count();
    if ($urandom_range(0, 5) == 0) begin
      position_text.push_back(CH_SPACE);
      repeat ($urandom_range(1, 4)) position_text.push_back(8'($urandom_range(33, 255)));
    end
    // cut short: the header still follows on the final character
    if (style == 7) begin
      n = $urandom_range(1, position_text.size());
      while (position_text.size() > n) void'(position_text.pop_back());
    end
  endtask

  task automatic send_item(input logic [7:0] ch, input logic eos);
    in_valid      <= 1'b1;
    character     <= ch;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
    if (!calm && sender_idle_odds != 0 && $urandom_range(1, sender_idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_text();
    foreach (position_text[i]) send_item(position_text[i], i == position_text.size() - 1);
  endtask

  // Receiver: random stalls, long ready stretches and one long hold-off
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && items_sent >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 5) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 16))
          @(posedge clk);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // junk and skipped characters, every piece, side, castling, passant, counters
    position_text = {8'h00, 8'hFF, CH_SLASH, CH_0, CH_9,
                     CH_LOWER_P, CH_LOWER_R - CASE_SHIFT, CH_LOWER_N,
                     CH_LOWER_B - CASE_SHIFT, CH_LOWER_Q, CH_UPPER_K, CH_8,
                     CH_SPACE, CH_LOWER_B, CH_SPACE,
                     CH_UPPER_K, CH_UPPER_Q, CH_LOWER_K, CH_LOWER_Q, CH_SPACE,
                     8'(CH_LOWER_A + 4), CH_3, CH_SPACE, 8'(CH_0 + 7), CH_SPACE, CH_9};
    send_text();

    while (items_sent < ITEM_TARGET) begin
      sender_idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
      compose_position($urandom_range(0, 9));
      send_text();
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (results_awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("[fen_position_parser] OK");
    else
      $display("[fen_position_parser] ERROR");
    $finish;
  end

endmodule
